// ----- hw/rtl/i2c_ebw_pkg.sv -----
// Shared types and constants for the I2C EEPROM byte-write master.
// Holds the input and result beat layouts, register indexes and reset values.
// No dependencies.
package i2c_ebw_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_LIMIT = 1'b1;

  // Register reset values
  localparam logic [7:0] DEV_ADDR_RST  = 8'hA0;
  localparam logic [3:0] ACK_LIMIT_RST = 4'd10;

  // Configuration write data is as wide as the widest register
  localparam int unsigned CFG_DATA_W = 8;

  // Sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_START = 5'b00010,
    PH_BITS  = 5'b00100,
    PH_ACK   = 5'b01000,
    PH_STOP  = 5'b10000
  } phase_t;

  // One input beat: one bus tick
  typedef struct packed {
    logic       start_request;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic       sda_sample;
  } in_t;

  // One result beat: line levels and status after the tick
  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic nack_seen;
  } out_t;

endpackage

// ----- hw/rtl/i2c_eeprom_byte_write_master.sv -----
// I2C EEPROM byte-write master: start, three bytes with ack slots, stop.
// Single register stage after the tick sequencer logic: result beat is valid
// the cycle after its input beat, and 1 beat per cycle unless a result stalls.
// A new beat is taken while a result waits if that result is taken the same cycle.
// Reset (rst_n low, synchronous): sequencer idle, both lines high, registers
// at their defaults, no result pending.
module i2c_eeprom_byte_write_master (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  i2c_ebw_pkg::in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output i2c_ebw_pkg::out_t                    out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [i2c_ebw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2c_ebw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import i2c_ebw_pkg::*;

  // Configuration registers
  logic [7:0] dev_addr_r;
  logic [3:0] ack_limit_r;

  // Sequencer state
  phase_t     phase_r,    phase_nxt;
  logic [1:0] step_r,     step_nxt;
  logic [1:0] byte_idx_r, byte_idx_nxt;
  logic [2:0] bit_cnt_r,  bit_cnt_nxt;
  logic [3:0] poll_cnt_r, poll_cnt_nxt;
  logic       nack_r,     nack_nxt;
  logic       scl_r,      scl_nxt;
  logic       sda_r,      sda_nxt;
  logic [7:0] shift_r,    shift_nxt;
  logic [7:0] addr_r,     addr_nxt;
  logic [7:0] data_r,     data_nxt;

  // Result register
  logic out_valid_r;
  out_t out_data_r, out_data_nxt;

  logic       accept;
  logic       done;
  logic       drive;
  logic [3:0] limit;
  logic [3:0] poll_inc;
  logic [7:0] load_val;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Zero limit still samples once
  assign limit    = (ack_limit_r == 4'd0) ? 4'd1 : ack_limit_r;
  assign poll_inc = poll_cnt_r + 4'd1;

  // Next byte to shift out, picked by the byte index after it advances
  always_comb begin
    unique case (byte_idx_nxt)
      2'd0:    load_val = dev_addr_r;
      2'd1:    load_val = addr_r;
      default: load_val = data_r;
    endcase
  end

  // Tick sequencer
  always_comb begin
    phase_nxt    = phase_r;
    step_nxt     = step_r;
    byte_idx_nxt = byte_idx_r;
    bit_cnt_nxt  = bit_cnt_r;
    poll_cnt_nxt = poll_cnt_r;
    nack_nxt     = nack_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    shift_nxt    = shift_r;
    addr_nxt     = addr_r;
    data_nxt     = data_r;
    done         = 1'b0;

    unique case (phase_r)
      PH_START: begin
        if (step_r == 2'd0) begin
          sda_nxt  = 1'b0;
          step_nxt = 2'd1;
        end else begin
          scl_nxt     = 1'b0;
          shift_nxt   = load_val;
          bit_cnt_nxt = 3'd0;
          phase_nxt   = PH_BITS;
          step_nxt    = 2'd0;
        end
      end
      PH_BITS: begin
        if (step_r == 2'd0) begin
          sda_nxt  = shift_r[7];
          step_nxt = 2'd1;
        end else if (step_r == 2'd1) begin
          scl_nxt  = 1'b1;
          step_nxt = 2'd2;
        end else begin
          scl_nxt   = 1'b0;
          shift_nxt = {shift_r[6:0], 1'b0};
          step_nxt  = 2'd0;
          if (bit_cnt_r == 3'd7) begin
            phase_nxt = PH_ACK;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
          end
        end
      end
      PH_ACK: begin
        if (step_r == 2'd0) begin
          // release SDA, raise SCL
          sda_nxt      = 1'b1;
          scl_nxt      = 1'b1;
          poll_cnt_nxt = 4'd0;
          step_nxt     = 2'd1;
        end else if (step_r == 2'd1) begin
          if (!in_data.sda_sample) begin
            step_nxt = 2'd2;
          end else begin
            poll_cnt_nxt = poll_inc;
            if (poll_inc >= limit) begin
              nack_nxt = 1'b1;
              step_nxt = 2'd2;
            end
          end
        end else begin
          scl_nxt  = 1'b0;
          step_nxt = 2'd0;
          if (byte_idx_r != 2'd2 && byte_idx_r != 2'd3) begin
            byte_idx_nxt = byte_idx_r + 2'd1;
            shift_nxt    = load_val;
            bit_cnt_nxt  = 3'd0;
            phase_nxt    = PH_BITS;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        if (step_r == 2'd0) begin
          sda_nxt  = 1'b0;
          step_nxt = 2'd1;
        end else if (step_r == 2'd1) begin
          scl_nxt  = 1'b1;
          step_nxt = 2'd2;
        end else begin
          sda_nxt   = 1'b1;
          done      = 1'b1;
          phase_nxt = PH_IDLE;
          step_nxt  = 2'd0;
        end
      end
      default: begin
        // idle: lines high, wait for a start request
        phase_nxt = PH_IDLE;
        step_nxt  = 2'd0;
        scl_nxt   = 1'b1;
        sda_nxt   = 1'b1;
        if (in_data.start_request) begin
          addr_nxt     = in_data.word_address;
          data_nxt     = in_data.write_data;
          nack_nxt     = 1'b0;
          byte_idx_nxt = 2'd0;
          bit_cnt_nxt  = 3'd0;
          poll_cnt_nxt = 4'd0;
          phase_nxt    = PH_START;
        end
      end
    endcase

    // Result beat from the updated state
    drive                  = !(phase_nxt == PH_ACK && step_nxt != 2'd0);
    out_data_nxt.scl_level = scl_nxt;
    out_data_nxt.sda_level = drive ? sda_nxt : 1'b1;
    out_data_nxt.sda_drive = drive;
    out_data_nxt.busy_res  = (phase_nxt != PH_IDLE);
    out_data_nxt.done_res  = done;
    out_data_nxt.nack_seen = nack_nxt;
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RST;
      ack_limit_r <= ACK_LIMIT_RST;
      phase_r     <= PH_IDLE;
      step_r      <= 2'd0;
      byte_idx_r  <= 2'd0;
      bit_cnt_r   <= 3'd0;
      poll_cnt_r  <= 4'd0;
      nack_r      <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DEV_ADDR:  dev_addr_r  <= cfg_data[7:0];
          REG_ACK_LIMIT: ack_limit_r <= cfg_data[3:0];
          default:       ;
        endcase
      end
      if (accept) begin
        phase_r    <= phase_nxt;
        step_r     <= step_nxt;
        byte_idx_r <= byte_idx_nxt;
        bit_cnt_r  <= bit_cnt_nxt;
        poll_cnt_r <= poll_cnt_nxt;
        nack_r     <= nack_nxt;
        scl_r      <= scl_nxt;
        sda_r      <= sda_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      shift_r    <= shift_nxt;
      addr_r     <= addr_nxt;
      data_r     <= data_nxt;
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- hw/rtl/i2c_ebw_checker.sv -----
// Port-level checks for the I2C EEPROM byte-write master, bound to the top level.
// Depends on i2c_ebw_pkg for the result beat layout.
module i2c_ebw_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input i2c_ebw_pkg::out_t out_data
);
  import i2c_ebw_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Input side only stalls behind a pending result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no pending result");

  // Done beat ends the transaction
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res
      && out_data.scl_level && out_data.sda_level && out_data.sda_drive)
    else $error("done beat with bus not released");

  // SDA is released only in an ack slot with SCL high
  a_ack_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sda_drive |-> out_data.busy_res
      && out_data.scl_level && out_data.sda_level)
    else $error("SDA released outside an ack slot");

endmodule

bind i2c_eeprom_byte_write_master i2c_ebw_checker u_i2c_ebw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
